// File: src/hsv565_pkg.sv
// Package for the HSV hexcone to RGB565 converter: field widths, hexcone
// segment bounds and register word indexes. It depends on nothing else.
package hsv565_pkg;

  // Field widths.
  localparam int unsigned HUE_W  = 11;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PACK_W = 16;

  // Configuration port widths.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Hexcone segment bounds on the 1530-step wheel.
  localparam logic [HUE_W-1:0] SEG_STEP    = 11'd255;
  localparam logic [HUE_W-1:0] SEG_TWO     = 11'd510;
  localparam logic [HUE_W-1:0] SEG_THREE   = 11'd765;
  localparam logic [HUE_W-1:0] SEG_FOUR    = 11'd1020;
  localparam logic [HUE_W-1:0] SEG_FIVE    = 11'd1275;
  localparam logic [HUE_W-1:0] WHEEL_STEPS = 11'd1530;

  // Full and empty channel levels.
  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
  localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

  // Register word indexes, taken from paddr bit 2.
  localparam logic REG_SATURATION = 1'b0;
  localparam logic REG_VALUE      = 1'b1;

  // Reset values of the registers.
  localparam logic [CHAN_W-1:0] SATURATION_RESET = 8'd255;
  localparam logic [CHAN_W-1:0] VALUE_RESET      = 8'd128;

endpackage

// File: src/hsv565_hue_if.sv
// Request channel carrying one hue per request.
// Depends on hsv565_pkg for the field width.
interface hsv565_hue_if;
  logic                            valid;
  logic                            ready;
  logic [hsv565_pkg::HUE_W-1:0]    hue;

  modport source (output valid, output hue, input ready);
  modport sink   (input valid, input hue, output ready);
endinterface

// File: src/hsv565_rgb_if.sv
// Result channel carrying the three colour channels and their RGB565 packing.
// Depends on hsv565_pkg for the field widths.
interface hsv565_rgb_if;
  logic                            valid;
  logic                            ready;
  logic [hsv565_pkg::CHAN_W-1:0]   red;
  logic [hsv565_pkg::CHAN_W-1:0]   green;
  logic [hsv565_pkg::CHAN_W-1:0]   blue;
  logic [hsv565_pkg::PACK_W-1:0]   color_565;

  modport source (output valid, output red, output green, output blue,
                  output color_565, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input color_565, output ready);
endinterface

// File: src/hsv_hexcone_to_rgb565.sv
// Top level of the HSV hexcone to RGB565 converter.
// Depends on hsv565_pkg, hsv565_hue_if and hsv565_rgb_if.
//
// Usage
//   The pixel channel takes one 11-bit hue per request (0 to 1529 around the
//   wheel; 1530 and above give pure red). The color channel returns one
//   request per hue: 8-bit red, green and blue after saturation and value,
//   and the RGB565 packing of those three.
//   Saturation (address 0) and brightness value (address 4) are written over
//   the APB-style port; the user must write them only while no request is
//   in flight, which the block does not enforce. Reads return the current values.
//   An accepted hue passes through the hexcone ramp, saturation multiply, value
//   multiply and packing stages to its colour on the output register.
//   Throughput is one hue per cycle while the receiver does not stall; the two
//   8x9 multiplier stages set the clock period.
//   Reset clears all stage valid bits and loads saturation 255 and value 128.
//   When the receiver stalls, each stage holds its request and an empty
//   stage keeps filling, so up to four requests are held before pixel.ready
//   drops; nothing is lost or repeated.
module hsv_hexcone_to_rgb565 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hsv565_pkg::ADDR_W-1:0]      paddr,
  input  logic [hsv565_pkg::DATA_W-1:0]      pwdata,
  output logic [hsv565_pkg::DATA_W-1:0]      prdata,
  output logic                               pready,
  hsv565_hue_if.sink                         pixel,
  hsv565_rgb_if.source                       color
);

  // Configuration registers.
  logic [hsv565_pkg::CHAN_W-1:0] saturation;
  logic [hsv565_pkg::CHAN_W-1:0] brightness_value;
  logic                          cfg_write;

  // Stage valid bits and advance enables.
  logic v1, v2, v3, vo;
  logic adv1, adv2, adv3, adv4;

  // Stage data.
  logic [hsv565_pkg::CHAN_W-1:0] r1, g1, b1;
  logic [hsv565_pkg::CHAN_W-1:0] r2, g2, b2;
  logic [hsv565_pkg::CHAN_W-1:0] r3, g3, b3;
  logic [hsv565_pkg::CHAN_W-1:0] ro, go, bo;
  logic [hsv565_pkg::PACK_W-1:0] packo;

  // Hexcone ramp outputs, before the first register.
  logic [hsv565_pkg::CHAN_W-1:0] r1_next, g1_next, b1_next;

  // Saturation: (c * (1 + s) >> 8) + (255 - s); the sum never exceeds 255.
  function automatic logic [hsv565_pkg::CHAN_W-1:0] apply_sat(
    input logic [hsv565_pkg::CHAN_W-1:0] c,
    input logic [hsv565_pkg::CHAN_W-1:0] s
  );
    logic [16:0] prod;
    logic [8:0]  sum;
    prod = 17'(c) * (17'(s) + 17'd1);
    sum  = 9'(prod >> 8) + 9'(hsv565_pkg::CHAN_FULL - s);
    return sum[7:0];
  endfunction

  // Value: c * (1 + v) >> 8, at most 255.
  function automatic logic [hsv565_pkg::CHAN_W-1:0] apply_val(
    input logic [hsv565_pkg::CHAN_W-1:0] c,
    input logic [hsv565_pkg::CHAN_W-1:0] v
  );
    logic [16:0] prod;
    prod = 17'(c) * (17'(v) + 17'd1);
    return prod[15:8];
  endfunction

  // Register port: writes land in the access phase, pready is always high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation       <= hsv565_pkg::SATURATION_RESET;
      brightness_value <= hsv565_pkg::VALUE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        hsv565_pkg::REG_SATURATION: saturation       <= pwdata[7:0];
        hsv565_pkg::REG_VALUE:      brightness_value <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hsv565_pkg::REG_SATURATION: prdata = 32'(saturation);
      hsv565_pkg::REG_VALUE:      prdata = 32'(brightness_value);
      default:                    prdata = '0;
    endcase
  end

  // Each stage moves on when it is empty or the next stage takes its request.
  assign adv4        = !vo || color.ready;
  assign adv3        = !v3 || adv4;
  assign adv2        = !v2 || adv3;
  assign adv1        = !v1 || adv2;
  assign pixel.ready = adv1;

  // Hexcone ramp: pick the segment and derive the rising or falling channel.
  always_comb begin
    r1_next = hsv565_pkg::CHAN_FULL;
    g1_next = hsv565_pkg::CHAN_ZERO;
    b1_next = hsv565_pkg::CHAN_ZERO;
    if (pixel.hue < hsv565_pkg::SEG_STEP) begin
      g1_next = pixel.hue[7:0];
    end else if (pixel.hue < hsv565_pkg::SEG_TWO) begin
      r1_next = 8'(hsv565_pkg::SEG_TWO - pixel.hue);
      g1_next = hsv565_pkg::CHAN_FULL;
    end else if (pixel.hue < hsv565_pkg::SEG_THREE) begin
      r1_next = hsv565_pkg::CHAN_ZERO;
      g1_next = hsv565_pkg::CHAN_FULL;
      b1_next = 8'(pixel.hue - hsv565_pkg::SEG_TWO);
    end else if (pixel.hue < hsv565_pkg::SEG_FOUR) begin
      r1_next = hsv565_pkg::CHAN_ZERO;
      g1_next = 8'(hsv565_pkg::SEG_FOUR - pixel.hue);
      b1_next = hsv565_pkg::CHAN_FULL;
    end else if (pixel.hue < hsv565_pkg::SEG_FIVE) begin
      r1_next = 8'(pixel.hue - hsv565_pkg::SEG_FOUR);
      b1_next = hsv565_pkg::CHAN_FULL;
    end else if (pixel.hue < hsv565_pkg::WHEEL_STEPS) begin
      b1_next = 8'(hsv565_pkg::WHEEL_STEPS - pixel.hue);
    end
  end

  // Valid bits travel with the data through the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (adv1) v1 <= pixel.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) vo <= v3;
    end
  end

  // Stage one: hexcone ramp.
  always_ff @(posedge clk) begin
    if (adv1) begin
      r1 <= r1_next;
      g1 <= g1_next;
      b1 <= b1_next;
    end
  end

  // Stage two: saturation.
  always_ff @(posedge clk) begin
    if (adv2) begin
      r2 <= apply_sat(r1, saturation);
      g2 <= apply_sat(g1, saturation);
      b2 <= apply_sat(b1, saturation);
    end
  end

  // Stage three: value.
  always_ff @(posedge clk) begin
    if (adv3) begin
      r3 <= apply_val(r2, brightness_value);
      g3 <= apply_val(g2, brightness_value);
      b3 <= apply_val(b2, brightness_value);
    end
  end

  // Output register with the RGB565 packing.
  always_ff @(posedge clk) begin
    if (adv4) begin
      ro    <= r3;
      go    <= g3;
      bo    <= b3;
      packo <= {r3[7:3], g3[7:2], b3[7:3]};
    end
  end

  assign color.valid     = vo;
  assign color.red       = ro;
  assign color.green     = go;
  assign color.blue      = bo;
  assign color.color_565 = packo;

`ifndef SYNTHESIS
  // An accepted hue always occupies stage one in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> v1)
    else $error("accepted hue did not reach stage one");

  // A hexcone colour has one channel at zero and one at full level.
  assert property (@(posedge clk) disable iff (rst)
    v1 |-> ((r1 == hsv565_pkg::CHAN_ZERO) || (g1 == hsv565_pkg::CHAN_ZERO) ||
            (b1 == hsv565_pkg::CHAN_ZERO)) &&
           ((r1 == hsv565_pkg::CHAN_FULL) || (g1 == hsv565_pkg::CHAN_FULL) ||
            (b1 == hsv565_pkg::CHAN_FULL)))
    else $error("stage one colour is not on the hexcone");

  // A blocked value stage keeps its request.
  assert property (@(posedge clk) disable iff (rst)
    (v3 && !adv4) |=> (v3 && $stable(r3) && $stable(g3) && $stable(b3)))
    else $error("value stage lost its request during a stall");

  // With zero saturation every colour comes out grey.
  assert property (@(posedge clk) disable iff (rst)
    (vo && (saturation == hsv565_pkg::CHAN_ZERO)) |-> ((ro == go) && (go == bo)))
    else $error("unsaturated colour is not grey");
`endif

endmodule

// File: tb/hsv565_colour_checker.sv
// Checker for the HSV hexcone to RGB565 converter: watches both request
// channels, the hue and the colour channel, and the APB-style port, predicts every colour and compares it.
// Depends on hsv565_pkg, hsv565_hue_if and hsv565_rgb_if.
module hsv565_colour_checker (
  input  logic                          clk,
  input  logic                          rst,
  hsv565_hue_if                         pixel,
  hsv565_rgb_if                         color,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [hsv565_pkg::ADDR_W-1:0] paddr,
  input  logic [hsv565_pkg::DATA_W-1:0] pwdata,
  input  logic [hsv565_pkg::DATA_W-1:0] prdata,
  output int                            mismatch_count,
  output int                            outstanding,
  output int                            colours_seen
);
  import hsv565_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [PACK_W-1:0] color_565;
  } colour_t;

  colour_t           expected_colours[$];
  logic [CHAN_W-1:0] saturation_copy;
  logic [CHAN_W-1:0] value_copy;

  // Fades a ramp level towards white by the saturation, then scales it by
  // the value; the sum is at most 255 and the product stays below 2^16.
  function automatic logic [CHAN_W-1:0] shade_level(input logic [CHAN_W-1:0] level,
                                                    input logic [CHAN_W-1:0] sat,
                                                    input logic [CHAN_W-1:0] val);
    int unsigned faded;
    faded = ((int'(level) * (int'(sat) + 1)) >> 8) + (int'(CHAN_FULL) - int'(sat));
    return CHAN_W'((faded * (int'(val) + 1)) >> 8);
  endfunction

  // Works out the shaded colour of one hue on the hexcone.
  function automatic colour_t hexcone_colour(input logic [HUE_W-1:0] hue,
                                             input logic [CHAN_W-1:0] sat,
                                             input logic [CHAN_W-1:0] val);
    logic [HUE_W-1:0] r;
    logic [HUE_W-1:0] g;
    logic [HUE_W-1:0] b;
    colour_t          res;
    if (hue < SEG_TWO) begin
      b = HUE_W'(CHAN_ZERO);
      if (hue < SEG_STEP) begin
        r = HUE_W'(CHAN_FULL);
        g = hue;
      end else begin
        r = SEG_TWO - hue;
        g = HUE_W'(CHAN_FULL);
      end
    end else if (hue < SEG_FOUR) begin
      r = HUE_W'(CHAN_ZERO);
      if (hue < SEG_THREE) begin
        g = HUE_W'(CHAN_FULL);
        b = hue - SEG_TWO;
      end else begin
        g = SEG_FOUR - hue;
        b = HUE_W'(CHAN_FULL);
      end
    end else if (hue < WHEEL_STEPS) begin
      g = HUE_W'(CHAN_ZERO);
      if (hue < SEG_FIVE) begin
        r = hue - SEG_FOUR;
        b = HUE_W'(CHAN_FULL);
      end else begin
        r = HUE_W'(CHAN_FULL);
        b = WHEEL_STEPS - hue;
      end
    end else begin
      // Past the end of the wheel the colour is pure red.
      r = HUE_W'(CHAN_FULL);
      g = HUE_W'(CHAN_ZERO);
      b = HUE_W'(CHAN_ZERO);
    end
    res.red       = shade_level(r[CHAN_W-1:0], sat, val);
    res.green     = shade_level(g[CHAN_W-1:0], sat, val);
    res.blue      = shade_level(b[CHAN_W-1:0], sat, val);
    res.color_565 = {res.red[7:3], res.green[7:2], res.blue[7:3]};
    return res;
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Tracks the registers, queues a prediction per hue and checks each colour.
  always @(posedge clk) begin
    colour_t           want;
    logic [CHAN_W-1:0] reg_now;
    if (rst) begin
      expected_colours.delete();
      saturation_copy = SATURATION_RESET;
      value_copy      = VALUE_RESET;
      mismatch_count  = 0;
      colours_seen    = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_SATURATION) begin
            saturation_copy = pwdata[CHAN_W-1:0];
          end else begin
            value_copy = pwdata[CHAN_W-1:0];
          end
        end else begin
          reg_now = (paddr[2] == REG_SATURATION) ? saturation_copy : value_copy;
          if (prdata !== DATA_W'(reg_now)) begin
            $error("prdata: expected %0d, got %0d", reg_now, prdata);
            mismatch_count++;
          end
        end
      end

      if (pixel.valid && pixel.ready) begin
        expected_colours.push_back(hexcone_colour(pixel.hue, saturation_copy, value_copy));
      end

      if (color.valid && color.ready) begin
        colours_seen++;
        if (expected_colours.size() == 0) begin
          $error("colour request with no hue waiting: red %0d green %0d blue %0d",
                 color.red, color.green, color.blue);
          mismatch_count++;
        end else begin
          want = expected_colours.pop_front();
          compare_field("red", int'(want.red), int'(color.red));
          compare_field("green", int'(want.green), int'(color.green));
          compare_field("blue", int'(want.blue), int'(color.blue));
          compare_field("color_565", int'(want.color_565), int'(color.color_565));
        end
      end
    end
    outstanding <= expected_colours.size();
  end

endmodule

// File: tb/hsv_hexcone_to_rgb565_tb.sv
// Testbench top for the HSV hexcone to RGB565 converter: clock, reset, hue
// stimulus, register settings and the colour receiver, plus the verdict.
// Depends on hsv565_pkg, both channel interfaces, the block and the checker.
module hsv_hexcone_to_rgb565_tb;
  import hsv565_pkg::*;

  localparam int PHASES     = 12;
  localparam int PHASE_HUES = 112;
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_PHASE = 5;
  localparam int HUE_MAX    = (1 << HUE_W) - 1;

  localparam logic [ADDR_W-1:0] SATURATION_ADDR = {REG_SATURATION, 2'b00};
  localparam logic [ADDR_W-1:0] VALUE_ADDR      = {REG_VALUE, 2'b00};

  // Segment edges, the end of the wheel, the top of the field and bit patterns.
  localparam logic [HUE_W-1:0] EDGE_HUES [22] = '{
    11'd0, 11'd1, 11'd254, 11'd255, 11'd256, 11'd509, 11'd510, 11'd764,
    11'd765, 11'd1019, 11'd1020, 11'd1274, 11'd1275, 11'd1528, 11'd1529,
    11'd1530, 11'd1531, 11'd2046, 11'd2047, 11'd1024, 11'd682, 11'd1365
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int outstanding;
  int colours_seen;
  int hues_sent;
  int past_wheel;
  int settings_used;
  bit src_idle;
  bit snk_idle;
  bit hold_request;

  hsv565_hue_if pixel_ch ();
  hsv565_rgb_if color_ch ();

  hsv_hexcone_to_rgb565 i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixel   (pixel_ch),
    .color   (color_ch)
  );

  hsv565_colour_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .pixel          (pixel_ch),
    .color          (color_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .colours_seen   (colours_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offers one hue, after a random gap while the source may idle; valid is left high for the next one.
  task automatic send_hue(input logic [HUE_W-1:0] hue);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.hue   <= hue;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    hues_sent++;
    if (hue >= WHEEL_STEPS) past_wheel++;
  endtask

  // Stops offering hues and waits until every predicted colour has come back.
  task automatic settle_colours();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One APB access: setup, access, then idle.
  task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Colour receiver: random stalls per request while the sink may idle, and one long hold on demand.
  initial begin : colour_sink
    int stall;
    color_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        color_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = snk_idle ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        color_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      color_ch.ready <= 1'b1;
      @(posedge clk);
      while (!color_ch.valid) @(posedge clk);
    end
  end

  // Stimulus: reset, directed hues, then phases of register settings.
  initial begin : hue_source
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] val;
    logic [HUE_W-1:0]  hue;
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.hue   <= '0;
    src_idle       = 1'b1;
    snk_idle       = 1'b1;
    hold_request   = 1'b0;
    hues_sent      = 0;
    past_wheel     = 0;
    settings_used  = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values read back, then the directed hues at those settings.
    apb_access(1'b0, SATURATION_ADDR, '0);
    apb_access(1'b0, VALUE_ADDR, '0);
    foreach (EDGE_HUES[i]) send_hue(EDGE_HUES[i]);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle_colours();
      case (phase)
        0:       begin sat = 8'd255; val = 8'd255; end
        1:       begin sat = 8'd0;   val = 8'd0;   end
        2:       begin sat = 8'd0;   val = 8'd255; end
        3:       begin sat = 8'd255; val = 8'd0;   end
        4:       begin sat = 8'd1;   val = 8'd254; end
        default: begin sat = CHAN_W'($urandom()); val = CHAN_W'($urandom()); end
      endcase
      // The upper bits carry noise; only the low byte is kept.
      apb_access(1'b1, SATURATION_ADDR, {24'($urandom()), sat});
      apb_access(1'b1, VALUE_ADDR, {24'($urandom()), val});
      apb_access(1'b0, SATURATION_ADDR, '0);
      apb_access(1'b0, VALUE_ADDR, '0);
      settings_used++;

      src_idle = (phase % 4) != 1;
      snk_idle = (phase % 3) != 2;
      if (phase == HOLD_PHASE) begin
        // Keep offering hues while the receiver holds off, so the block fills.
        src_idle     = 1'b0;
        hold_request = 1'b1;
      end

      for (int n = 0; n < PHASE_HUES; n++) begin
        case ($urandom_range(0, 9))
          0:       hue = HUE_W'($urandom_range(int'(WHEEL_STEPS), HUE_MAX));
          // Within one step of a segment edge.
          1, 2:    hue = HUE_W'(int'(SEG_STEP) * $urandom_range(1, 6)
                                + $urandom_range(0, 2) - 1);
          default: hue = HUE_W'($urandom_range(0, int'(WHEEL_STEPS) - 1));
        endcase
        send_hue(hue);
      end
    end

    settle_colours();
    repeat (8) @(posedge clk);
    $display("Sent %0d hues (%0d past the wheel) under %0d saturation and value settings,",
             hues_sent, past_wheel, settings_used);
    $display("with a %0d-cycle receiver hold; %0d colours came back.",
             LONG_HOLD, colours_seen);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin : watchdog
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
